### rtl/selective_repeat_receive_window_defines.svh
// ----------------------------------------------------------------------------
// selective repeat receive window: assertion macros
// Concurrent assertion wrappers clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_DEFINES_SVH

`ifndef SYNTHESIS
// property holds at every clock edge
`define SRW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// consequent holds in the cycle after the antecedent
`define SRW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SRW_ASSERT(label, prop, msg)
`define SRW_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### rtl/srw_pkg.sv
// ----------------------------------------------------------------------------
// srw_pkg
// Shared widths, result type and sequence helpers of the receive window.
// ----------------------------------------------------------------------------
`default_nettype none

package srw_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int MAP_DEPTH   = 2 * MAX_WINDOW;
  localparam int MAP_AW      = $clog2(MAP_DEPTH);
  localparam int DATA_W      = 8;
  localparam int SEQ_W       = 7;
  localparam int SPAN_W      = 8;
  localparam int WIN_RST     = 8;

  // one result item
  typedef struct packed {
    logic [SEQ_W-1:0] ack_seq;
    logic [SEQ_W-1:0] advanced;
    logic [SEQ_W-1:0] window_base;
  } res_t;

  // clamp the written window size into 1 .. MAX_WINDOW
  function automatic logic [SEQ_W-1:0] eff_window(input logic [SEQ_W-1:0] v);
    logic [SEQ_W-1:0] w;
    w = v;
    if (v == '0) begin
      w = SEQ_W'(1);
    end else if (v > SEQ_W'(MAX_WINDOW)) begin
      w = SEQ_W'(MAX_WINDOW);
    end
    return w;
  endfunction

  // sequence number plus one, modulo the sequence space
  function automatic logic [SEQ_W-1:0] next_seq(input logic [SEQ_W-1:0] seq,
                                                input logic [SPAN_W-1:0] span);
    logic [SPAN_W-1:0] inc;
    inc = {1'b0, seq} + SPAN_W'(1);
    return (inc == span) ? '0 : inc[SEQ_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/srw_frame_if.sv
// ----------------------------------------------------------------------------
// srw_frame_if
// Valid/ready channel carrying one received frame per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface srw_frame_if;
  logic                        valid;
  logic                        ready;
  logic [srw_pkg::DATA_W-1:0]  data_byte;
  logic [srw_pkg::DATA_W-1:0]  check_byte;
  logic [srw_pkg::SEQ_W-1:0]   seq_num;

  modport source (output valid, output data_byte, output check_byte, output seq_num,
                  input ready);
  modport sink   (input valid, input data_byte, input check_byte, input seq_num,
                  output ready);
endinterface

`default_nettype wire

### rtl/srw_ack_if.sv
// ----------------------------------------------------------------------------
// srw_ack_if
// Valid/ready channel carrying one acknowledgment per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface srw_ack_if;
  logic                       valid;
  logic                       ready;
  logic [srw_pkg::SEQ_W-1:0]  ack_seq;
  logic [srw_pkg::SEQ_W-1:0]  advanced;
  logic [srw_pkg::SEQ_W-1:0]  window_base;

  modport source (output valid, output ack_seq, output advanced, output window_base,
                  input ready);
  modport sink   (input valid, input ack_seq, input advanced, input window_base,
                  output ready);
endinterface

`default_nettype wire

### rtl/srw_ram.sv
// ----------------------------------------------------------------------------
// srw_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module srw_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/srw_ctrl.sv
// ----------------------------------------------------------------------------
// srw_ctrl
// Window sequencer: checks frames, marks the bitmap RAM and walks the run of
// received slots at the window base one RAM read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "selective_repeat_receive_window_defines.svh"

module srw_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [srw_pkg::SEQ_W-1:0]    cfg_wdata_i,
  srw_frame_if.sink                         in_i,
  output logic                              ram_we_o,
  output logic      [srw_pkg::MAP_AW-1:0]   ram_waddr_o,
  output logic      [0:0]                   ram_wdata_o,
  output logic      [srw_pkg::MAP_AW-1:0]   ram_raddr_o,
  input  wire logic [0:0]                   ram_rdata_i,
  output logic                              load_o,
  output srw_pkg::res_t                     res_o,
  input  wire logic                         free_i
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [srw_pkg::SEQ_W-1:0]    w_q, w_d;
  logic [srw_pkg::SPAN_W-1:0]   span_q, span_d;
  logic [srw_pkg::SEQ_W-1:0]    base_q, base_d;
  logic [srw_pkg::SEQ_W-1:0]    ptr_q, ptr_d;
  logic [srw_pkg::SEQ_W-1:0]    cnt_q, cnt_d;
  logic [srw_pkg::SEQ_W-1:0]    ack_q, ack_d;
  logic [srw_pkg::MAP_AW-1:0]   clr_q, clr_d;

  logic                         fire;
  logic                         chk_ok;
  logic                         seq_hit;
  logic [srw_pkg::SPAN_W-1:0]   diff;
  logic [srw_pkg::SPAN_W-1:0]   off;
  logic                         in_win;
  logic [srw_pkg::SEQ_W-1:0]    base_nx;
  logic [srw_pkg::SEQ_W-1:0]    ptr_nx;
  logic [srw_pkg::SEQ_W-1:0]    cnt_inc;
  logic [srw_pkg::SEQ_W-1:0]    cfg_w;

  // frame decode
  assign fire    = in_i.valid && in_i.ready;
  assign chk_ok  = (in_i.check_byte == ~in_i.data_byte);
  assign seq_hit = (in_i.seq_num == base_q);
  assign diff    = {1'b0, in_i.seq_num} - {1'b0, base_q};
  assign off     = diff[srw_pkg::SPAN_W-1] ? (diff + span_q) : diff;
  assign in_win  = ({1'b0, in_i.seq_num} < span_q) && (off < {1'b0, w_q});
  assign base_nx = srw_pkg::next_seq(base_q, span_q);
  assign ptr_nx  = srw_pkg::next_seq(ptr_q, span_q);
  assign cnt_inc = cnt_q + srw_pkg::SEQ_W'(1);
  assign cfg_w   = srw_pkg::eff_window(cfg_wdata_i);

  assign in_i.ready = (state_q == ST_IDLE);

  // result item from the held fields
  assign res_o.ack_seq     = ack_q;
  assign res_o.advanced    = cnt_q;
  assign res_o.window_base = base_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    w_d         = w_q;
    span_d      = span_q;
    base_d      = base_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    ack_d       = ack_q;
    clr_d       = clr_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = ptr_q;
    ram_wdata_o = 1'b0;
    ram_raddr_o = ptr_nx;
    load_o      = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        clr_d       = clr_q + srw_pkg::MAP_AW'(1);
        if (clr_q == srw_pkg::MAP_AW'(srw_pkg::MAP_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ram_raddr_o = base_nx;
        if (fire && chk_ok) begin
          state_d = ST_EMIT;
          if (seq_hit) begin
            // frame at the base: the base slot itself counts as received
            ack_d = base_q;
            cnt_d = srw_pkg::SEQ_W'(1);
            if (w_q == srw_pkg::SEQ_W'(1)) begin
              base_d = base_nx;
            end else begin
              ptr_d   = base_nx;
              state_d = ST_SCAN;
            end
          end else begin
            ack_d = in_i.seq_num;
            cnt_d = '0;
            if (in_win) begin
              ram_we_o    = 1'b1;
              ram_waddr_o = in_i.seq_num;
              ram_wdata_o = 1'b1;
            end
          end
        end
      end
      ST_SCAN: begin
        // read data belongs to ptr_q
        if (ram_rdata_i[0]) begin
          ram_we_o = 1'b1;
          cnt_d    = cnt_inc;
          if (cnt_inc < w_q) begin
            ptr_d = ptr_nx;
          end else begin
            base_d  = ptr_nx;
            state_d = ST_EMIT;
          end
        end else begin
          base_d  = ptr_q;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        load_o = free_i;
        if (free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase

    // a window size write restarts the session
    if (cfg_we_i) begin
      w_d     = cfg_w;
      span_d  = {cfg_w, 1'b0};
      base_d  = '0;
      clr_d   = '0;
      state_d = ST_CLEAR;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      w_q     <= srw_pkg::SEQ_W'(srw_pkg::WIN_RST);
      span_q  <= srw_pkg::SPAN_W'(2 * srw_pkg::WIN_RST);
      base_q  <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      w_q     <= w_d;
      span_q  <= span_d;
      base_q  <= base_d;
      clr_q   <= clr_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    cnt_q <= cnt_d;
    ack_q <= ack_d;
  end

  `SRW_ASSERT(a_base_in_span, {1'b0, base_q} < span_q, "window base outside sequence space")
  `SRW_ASSERT(a_scan_count, (state_q == ST_SCAN) |-> (cnt_q != '0 && cnt_q < w_q), "scan count out of window")
  `SRW_ASSERT(a_scan_not_base, (state_q == ST_SCAN) |-> (ptr_q != base_q), "scan wrapped onto base")
  `SRW_ASSERT_NEXT(a_cfg_restart, cfg_we_i, (state_q == ST_CLEAR) && (base_q == '0), "write did not restart")

endmodule

`default_nettype wire

### rtl/srw_out_stage.sv
// ----------------------------------------------------------------------------
// srw_out_stage
// Output register holding one acknowledgment item until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module srw_out_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          load_i,
  input  wire srw_pkg::res_t res_i,
  output logic               free_o,
  srw_ack_if.source          out_o
);

  logic          valid_q, valid_d;
  srw_pkg::res_t res_q;

  // slot frees when empty or being taken this cycle
  assign free_o  = !valid_q || out_o.ready;
  assign valid_d = load_i || (valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.ack_seq     = res_q.ack_seq;
  assign out_o.advanced    = res_q.advanced;
  assign out_o.window_base = res_q.window_base;

endmodule

`default_nettype wire

### rtl/selective_repeat_receive_window.sv
// ----------------------------------------------------------------------------
// selective_repeat_receive_window
// Selective-repeat ARQ receive window with its received bitmap in a RAM.
// ----------------------------------------------------------------------------
//  channel    dir  handshake         payload
//  in_i       in   valid / ready     data_byte, check_byte, seq_num
//  out_o      out  valid / ready     ack_seq, advanced, window_base
//  cfg        in   cfg_we_i          cfg_wdata_i (window size)
//
// A frame that fails its check is dropped in ST_IDLE; any other frame off the base goes
// to ST_EMIT. For a frame at the window base in a window wider than one, the bitmap RAM
// is walked one slot per cycle through its single registered read port.
// After reset and after every window size write a clearing pass zeroes the
// 128-entry bitmap, with in_i.ready low.
// A result held back by out_o.ready keeps the block from taking the next frame.
// ----------------------------------------------------------------------------
`default_nettype none

module selective_repeat_receive_window (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [srw_pkg::SEQ_W-1:0]  cfg_wdata_i,
  srw_frame_if.sink                       in_i,
  srw_ack_if.source                       out_o
);

  logic                        ram_we;
  logic [srw_pkg::MAP_AW-1:0]  ram_waddr;
  logic [0:0]                  ram_wdata;
  logic [srw_pkg::MAP_AW-1:0]  ram_raddr;
  logic [0:0]                  ram_rdata;
  logic                        load;
  logic                        free;
  srw_pkg::res_t               res;

  // window sequencer
  srw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .load_o      (load),
    .res_o       (res),
    .free_i      (free)
  );

  // received bitmap
  srw_ram #(
    .WIDTH (1),
    .DEPTH (srw_pkg::MAP_DEPTH)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // acknowledgment register
  srw_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .res_i  (res),
    .free_o (free),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire
